// ===== rtl/vpk_pkg.sv =====
// vpk_pkg: widths, payload types and saturation limits for the pair kinematics block
// no dependencies; imported by vpk_if, vpk_front, v0_pair_kinematics and the bench
package vpk_pkg;

  localparam int MOM_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int MASS_W  = 40;
  localparam int ALPHA_W = 24;
  localparam int QT_W    = 24;

  // derived intermediate widths
  localparam int SUM_W   = MOM_W + 1;        // summed prong component
  localparam int PSQ_W   = 2 * MOM_W - 1;    // square of one component
  localparam int SQ_W    = 2 * MOM_W;        // squared norm of one vector
  localparam int SSQ_W   = 2 * SUM_W - 1;    // square of one summed component
  localparam int DEN_W   = 2 * SUM_W;        // squared norm of summed momentum
  localparam int XP_W    = 2 * MOM_W;        // one cross product term
  localparam int C_W     = XP_W + 1;         // cross product component
  localparam int CM_W    = XP_W;             // magnitude of a cross component
  localparam int HALF_W  = CM_W / 2;
  localparam int CN_W    = 2 * CM_W;         // squared norm of cross product
  localparam int RAD_W   = SQ_W + 2;         // energy radicand
  localparam int ROOT_W  = RAD_W / 2;
  localparam int E_W     = ROOT_W + 1;
  localparam int E2_W    = 2 * E_W;
  localparam int ANUM_W  = SQ_W + FRAC_W;    // alpha dividend
  localparam int ALPHA_QW = ALPHA_W - 1;     // alpha quotient bits below the limit
  localparam int QT_QW   = 2 * QT_W;         // qt squared quotient bits
  localparam int QT_K    = QT_QW / 2;
  localparam int FRONT_LAT = 6;

  localparam logic signed [ALPHA_W-1:0] ALPHA_MAX = {1'b0, {(ALPHA_W-1){1'b1}}};
  localparam logic signed [ALPHA_W-1:0] ALPHA_MIN = {1'b1, {(ALPHA_W-1){1'b0}}};
  localparam logic [QT_W-1:0]           QT_MAX    = {QT_W{1'b1}};

  typedef logic signed [MOM_W-1:0] mom_t;
  typedef logic [MOM_W-1:0]        msq_t;

  typedef struct packed {
    mom_t pos_px;
    mom_t pos_py;
    mom_t pos_pz;
    mom_t neg_px;
    mom_t neg_py;
    mom_t neg_pz;
    mom_t pair_px;
    mom_t pair_py;
    mom_t pair_pz;
    msq_t pos_mass_sq;
    msq_t neg_mass_sq;
  } vpk_item_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad_p;
    logic [RAD_W-1:0] rad_n;
    logic [SQ_W-1:0]  sq_v;
    logic [SQ_W-1:0]  num;
    logic             neg;
    logic             zero;
    logic [DEN_W-1:0] den;
    logic [CN_W-1:0]  cn;
  } vpk_front_t;

  typedef struct packed {
    logic signed [MASS_W-1:0]  inv_mass_sq;
    logic signed [ALPHA_W-1:0] ap_alpha;
    logic [QT_W-1:0]           ap_qt;
    logic                      zero_pair;
  } vpk_res_t;

endpackage

// ===== rtl/vpk_if.sv =====
// vpk_in_if and vpk_out_if: valid/ready request channels of the pair kinematics block
// depends on vpk_pkg for field widths
interface vpk_in_if import vpk_pkg::*;;
  logic valid;
  logic ready;
  mom_t pos_px;
  mom_t pos_py;
  mom_t pos_pz;
  mom_t neg_px;
  mom_t neg_py;
  mom_t neg_pz;
  mom_t pair_px;
  mom_t pair_py;
  mom_t pair_pz;
  msq_t pos_mass_sq;
  msq_t neg_mass_sq;

  modport source (output valid, pos_px, pos_py, pos_pz, neg_px, neg_py, neg_pz,
                  pair_px, pair_py, pair_pz, pos_mass_sq, neg_mass_sq, input ready);
  modport sink (input valid, pos_px, pos_py, pos_pz, neg_px, neg_py, neg_pz,
                pair_px, pair_py, pair_pz, pos_mass_sq, neg_mass_sq, output ready);
endinterface

interface vpk_out_if import vpk_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [MASS_W-1:0]  inv_mass_sq;
  logic signed [ALPHA_W-1:0] ap_alpha;
  logic [QT_W-1:0]           ap_qt;
  logic                      zero_pair;

  modport source (output valid, inv_mass_sq, ap_alpha, ap_qt, zero_pair, input ready);
  modport sink (input valid, inv_mass_sq, ap_alpha, ap_qt, zero_pair, output ready);
endinterface

// ===== rtl/vpk_delay.sv =====
// vpk_delay: enabled shift line that keeps side data aligned with the pipeline
// no package dependency
module vpk_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] d_out
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_in;
      for (int i = 1; i < D; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign d_out = sr_r[D-1];

endmodule

// ===== rtl/vpk_div.sv =====
// vpk_div: pipelined restoring divider, one quotient bit per stage, with overflow flag
// no package dependency
module vpk_div #(
  parameter int NW = 64,
  parameter int DW = 50,
  parameter int QW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int HW = NW - QW;
  localparam int MW = (HW > DW) ? HW : DW;

  logic [MW-1:0] hi_ext;
  logic [MW-1:0] den_ext;
  logic          ovf_in;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] d_r   [QW];
  logic          ovf_r [QW];

  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] lo_nxt  [QW];
  logic [QW-1:0] q_nxt   [QW];
  logic [DW-1:0] d_nxt   [QW];
  logic          ovf_nxt [QW];

  // quotient would not fit when the high part already reaches the divisor
  assign hi_ext  = MW'(num[NW-1:QW]);
  assign den_ext = MW'(den);
  assign ovf_in  = hi_ext >= den_ext;

  always_comb begin
    logic [DW-1:0] rp;
    logic [QW-1:0] lp;
    logic [QW-1:0] qp;
    logic [DW-1:0] dp;
    logic          op;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rp = DW'(num[NW-1:QW]);
        lp = num[QW-1:0];
        qp = '0;
        dp = den;
        op = ovf_in;
      end else begin
        rp = rem_r[k-1];
        lp = lo_r[k-1];
        qp = q_r[k-1];
        dp = d_r[k-1];
        op = ovf_r[k-1];
      end
      trial = {rp, lp[QW-1]};
      ge    = trial >= {1'b0, dp};
      diff  = trial - {1'b0, dp};
      rem_nxt[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
      lo_nxt[k]  = {lp[QW-2:0], 1'b0};
      q_nxt[k]   = {qp[QW-2:0], ge};
      d_nxt[k]   = dp;
      ovf_nxt[k] = op;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        q_r[k]   <= q_nxt[k];
        d_r[k]   <= d_nxt[k];
        ovf_r[k] <= ovf_nxt[k];
      end
    end
  end

  assign quo = q_r[QW-1];
  assign ovf = ovf_r[QW-1];

endmodule

// ===== rtl/vpk_isqrt.sv =====
// vpk_isqrt: pipelined floor square root, one root bit per stage
// no package dependency
module vpk_isqrt #(
  parameter int RW = 48
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RW-1:0]     rad,
  output logic [RW/2-1:0]   root
);

  localparam int K = RW / 2;

  logic [RW-1:0]  x_r    [K];
  logic [K+1:0]   rem_r  [K];
  logic [K-1:0]   root_r [K];

  logic [RW-1:0]  x_nxt    [K];
  logic [K+1:0]   rem_nxt  [K];
  logic [K-1:0]   root_nxt [K];

  always_comb begin
    logic [RW-1:0] xp;
    logic [K+1:0]  rp;
    logic [K-1:0]  op;
    logic [K+3:0]  t;
    logic [K+3:0]  trial;
    logic [K+3:0]  diff;
    logic          ge;
    for (int k = 0; k < K; k++) begin
      if (k == 0) begin
        xp = rad;
        rp = '0;
        op = '0;
      end else begin
        xp = x_r[k-1];
        rp = rem_r[k-1];
        op = root_r[k-1];
      end
      t     = {rp, xp[RW-1:RW-2]};
      trial = {2'b00, op, 2'b01};
      ge    = t >= trial;
      diff  = t - trial;
      rem_nxt[k]  = ge ? diff[K+1:0] : t[K+1:0];
      root_nxt[k] = {op[K-2:0], ge};
      x_nxt[k]    = {xp[RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < K; k++) begin
        x_r[k]    <= x_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root = root_r[K-1];

endmodule

// ===== rtl/vpk_front.sv =====
// vpk_front: six-stage front end with squares, cross product and squared norms
// depends on vpk_pkg for widths and the item and front-end structs
module vpk_front import vpk_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  vpk_item_t  item,
  output vpk_front_t fo
);

  function automatic logic [PSQ_W-1:0] sq_mom(input logic signed [MOM_W-1:0] x);
    logic signed [2*MOM_W-1:0] t;
    t = x * x;
    return t[PSQ_W-1:0];
  endfunction

  function automatic logic [SSQ_W-1:0] sq_sum(input logic signed [SUM_W-1:0] x);
    logic signed [2*SUM_W-1:0] t;
    t = x * x;
    return t[SSQ_W-1:0];
  endfunction

  function automatic logic signed [XP_W-1:0] mul_mom(input logic signed [MOM_W-1:0] a,
                                                     input logic signed [MOM_W-1:0] b);
    logic signed [XP_W-1:0] t;
    t = a * b;
    return t;
  endfunction

  function automatic logic [CM_W-1:0] mag_c(input logic signed [C_W-1:0] x);
    logic signed [C_W-1:0] t;
    t = (x < 0) ? -x : x;
    return t[CM_W-1:0];
  endfunction

  logic signed [MOM_W-1:0] p [3];
  logic signed [MOM_W-1:0] n [3];
  logic signed [MOM_W-1:0] v [3];

  assign p[0] = item.pos_px;
  assign p[1] = item.pos_py;
  assign p[2] = item.pos_pz;
  assign n[0] = item.neg_px;
  assign n[1] = item.neg_py;
  assign n[2] = item.neg_pz;
  assign v[0] = item.pair_px;
  assign v[1] = item.pair_py;
  assign v[2] = item.pair_pz;

  // stage a: component squares, cross terms, prong sum
  logic [PSQ_W-1:0]        psq_r [3];
  logic [PSQ_W-1:0]        nsq_r [3];
  logic [PSQ_W-1:0]        vsq_r [3];
  logic signed [XP_W-1:0]  xa_r  [3];
  logic signed [XP_W-1:0]  xb_r  [3];
  logic signed [SUM_W-1:0] s_r   [3];
  logic [MOM_W-1:0]        mp_a_r;
  logic [MOM_W-1:0]        mn_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        psq_r[i] <= sq_mom(p[i]);
        nsq_r[i] <= sq_mom(n[i]);
        vsq_r[i] <= sq_mom(v[i]);
        s_r[i]   <= SUM_W'(p[i]) + SUM_W'(n[i]);
      end
      xa_r[0] <= mul_mom(p[1], n[2]);
      xb_r[0] <= mul_mom(p[2], n[1]);
      xa_r[1] <= mul_mom(p[2], n[0]);
      xb_r[1] <= mul_mom(p[0], n[2]);
      xa_r[2] <= mul_mom(p[0], n[1]);
      xb_r[2] <= mul_mom(p[1], n[0]);
      mp_a_r  <= item.pos_mass_sq;
      mn_a_r  <= item.neg_mass_sq;
    end
  end

  // stage b: norms, cross components, summed squares
  logic [SSQ_W-1:0]      ssq_r [3];
  logic signed [C_W-1:0] c_r   [3];
  logic [SQ_W-1:0]       sqp_r;
  logic [SQ_W-1:0]       sqn_r;
  logic [SQ_W-1:0]       sqv_r;
  logic                  zero_b_r;
  logic [MOM_W-1:0]      mp_b_r;
  logic [MOM_W-1:0]      mn_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ssq_r[i] <= sq_sum(s_r[i]);
        c_r[i]   <= C_W'(xa_r[i]) - C_W'(xb_r[i]);
      end
      sqp_r    <= SQ_W'(psq_r[0]) + SQ_W'(psq_r[1]) + SQ_W'(psq_r[2]);
      sqn_r    <= SQ_W'(nsq_r[0]) + SQ_W'(nsq_r[1]) + SQ_W'(nsq_r[2]);
      sqv_r    <= SQ_W'(vsq_r[0]) + SQ_W'(vsq_r[1]) + SQ_W'(vsq_r[2]);
      zero_b_r <= (s_r[0] == '0) && (s_r[1] == '0) && (s_r[2] == '0);
      mp_b_r   <= mp_a_r;
      mn_b_r   <= mn_a_r;
    end
  end

  // stage c: radicands, alpha numerator, denominator, cross magnitudes
  vpk_front_t      c_pk_r;
  logic [CM_W-1:0] cm_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cm_r[i] <= mag_c(c_r[i]);
      end
      c_pk_r.rad_p <= RAD_W'({mp_b_r, {FRAC_W{1'b0}}}) + RAD_W'(sqp_r);
      c_pk_r.rad_n <= RAD_W'({mn_b_r, {FRAC_W{1'b0}}}) + RAD_W'(sqn_r);
      c_pk_r.sq_v  <= sqv_r;
      c_pk_r.neg   <= sqn_r > sqp_r;
      c_pk_r.num   <= (sqn_r > sqp_r) ? (sqn_r - sqp_r) : (sqp_r - sqn_r);
      c_pk_r.zero  <= zero_b_r;
      c_pk_r.den   <= DEN_W'(ssq_r[0]) + DEN_W'(ssq_r[1]) + DEN_W'(ssq_r[2]);
      c_pk_r.cn    <= '0;
    end
  end

  // stage d: partial products of the cross magnitudes squared
  logic [2*HALF_W-1:0] hh_r [3];
  logic [2*HALF_W-1:0] hl_r [3];
  logic [2*HALF_W-1:0] ll_r [3];
  vpk_front_t          d_pk_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= cm_r[i][CM_W-1:HALF_W] * cm_r[i][CM_W-1:HALF_W];
        hl_r[i] <= cm_r[i][CM_W-1:HALF_W] * cm_r[i][HALF_W-1:0];
        ll_r[i] <= cm_r[i][HALF_W-1:0] * cm_r[i][HALF_W-1:0];
      end
      d_pk_r <= c_pk_r;
    end
  end

  // stage e1: one square per component
  logic [CN_W-1:0] csq_r [3];
  vpk_front_t      e1_pk_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        csq_r[i] <= (CN_W'(hh_r[i]) << CM_W) + (CN_W'(hl_r[i]) << (HALF_W + 1))
                    + CN_W'(ll_r[i]);
      end
      e1_pk_r <= d_pk_r;
    end
  end

  // stage e2: squared norm of the cross product
  vpk_front_t fo_nxt;
  vpk_front_t fo_r;

  always_comb begin
    fo_nxt    = e1_pk_r;
    fo_nxt.cn = csq_r[0] + csq_r[1] + csq_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo_r <= fo_nxt;
    end
  end

  assign fo = fo_r;

endmodule

// ===== rtl/v0_pair_kinematics.sv =====
// v0_pair_kinematics: invariant mass squared and armenteros alpha and qt per candidate
// throughput one request per cycle; a stalled, full output buffer holds the pipeline
// two-entry output buffer lets requests enter while one result waits
// synchronous active-low reset clears valid bits and buffer pointers and count only
// depends on vpk_pkg, vpk_if, vpk_front, vpk_div, vpk_isqrt and vpk_delay
module v0_pair_kinematics import vpk_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  vpk_in_if.sink   in_chan,
  vpk_out_if.source out_chan
);

  // pipeline stage positions, counted in enabled cycles from acceptance
  localparam int MASS_DONE  = FRONT_LAT + ROOT_W + 3;
  localparam int ALPHA_DONE = FRONT_LAT + ALPHA_QW + 1;
  localparam int LAT        = FRONT_LAT + QT_QW + QT_K + 1;

  logic       en;
  logic [LAT-1:0] vld_r;
  vpk_item_t  item;
  vpk_front_t fo;

  // output buffer state
  vpk_res_t buf_r [2];
  logic     wr_ptr_r;
  logic     rd_ptr_r;
  logic [1:0] cnt_r;
  logic     push;
  logic     pop;
  vpk_res_t res_last;

  // whole pipeline advances unless the buffer is full and not being drained
  assign en            = (cnt_r != 2'd2) || out_chan.ready;
  assign in_chan.ready = en;

  assign item.pos_px      = in_chan.pos_px;
  assign item.pos_py      = in_chan.pos_py;
  assign item.pos_pz      = in_chan.pos_pz;
  assign item.neg_px      = in_chan.neg_px;
  assign item.neg_py      = in_chan.neg_py;
  assign item.neg_pz      = in_chan.neg_pz;
  assign item.pair_px     = in_chan.pair_px;
  assign item.pair_py     = in_chan.pair_py;
  assign item.pair_pz     = in_chan.pair_pz;
  assign item.pos_mass_sq = in_chan.pos_mass_sq;
  assign item.neg_mass_sq = in_chan.neg_mass_sq;

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_chan.valid};
    end
  end

  // squares, cross product, norms and radicands
  vpk_front u_front (
    .clk  (clk),
    .en   (en),
    .item (item),
    .fo   (fo)
  );

  // ---------------------------------------------------------------------
  // mass path: two energy roots, sum, square, subtract pair momentum
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] root_p;
  logic [ROOT_W-1:0] root_n;
  logic [SQ_W-1:0]   sqv_d;
  logic [E_W-1:0]    e_r;
  logic [SQ_W-1:0]   sqv1_r;
  logic [E2_W-1:0]   e2_r;
  logic [SQ_W-1:0]   sqv2_r;
  logic signed [E2_W:0] md;
  logic [MASS_W-1:0] mass_r;
  logic [MASS_W-1:0] mass_d;

  vpk_isqrt #(.RW(RAD_W)) u_sqrt_p (
    .clk  (clk),
    .en   (en),
    .rad  (fo.rad_p),
    .root (root_p)
  );

  vpk_isqrt #(.RW(RAD_W)) u_sqrt_n (
    .clk  (clk),
    .en   (en),
    .rad  (fo.rad_n),
    .root (root_n)
  );

  vpk_delay #(.W(SQ_W), .D(ROOT_W)) u_dly_sqv (
    .clk   (clk),
    .en    (en),
    .d_in  (fo.sq_v),
    .d_out (sqv_d)
  );

  // exact difference in doubled fraction units, then floor by arithmetic shift
  assign md = $signed({1'b0, e2_r}) - $signed({{(E2_W - SQ_W + 1){1'b0}}, sqv2_r});

  always_ff @(posedge clk) begin
    if (en) begin
      e_r    <= E_W'(root_p) + E_W'(root_n);
      sqv1_r <= sqv_d;
      e2_r   <= e_r * e_r;
      sqv2_r <= sqv1_r;
      mass_r <= MASS_W'(md >>> FRAC_W);
    end
  end

  vpk_delay #(.W(MASS_W), .D(LAT - MASS_DONE)) u_dly_mass (
    .clk   (clk),
    .en    (en),
    .d_in  (mass_r),
    .d_out (mass_d)
  );

  // ---------------------------------------------------------------------
  // alpha path: |sq_p - sq_n| scaled by the fraction, over the squared summed norm
  // ---------------------------------------------------------------------
  logic [ALPHA_QW-1:0] aq;
  logic                a_ovf;
  logic [1:0]          a_side;
  logic [ALPHA_W-1:0]  alpha_nxt;
  logic [ALPHA_W-1:0]  alpha_r;
  logic [ALPHA_W-1:0]  alpha_d;

  vpk_div #(.NW(ANUM_W), .DW(DEN_W), .QW(ALPHA_QW)) u_div_alpha (
    .clk (clk),
    .en  (en),
    .num (ANUM_W'({fo.num, {FRAC_W{1'b0}}})),
    .den (fo.den),
    .quo (aq),
    .ovf (a_ovf)
  );

  // sign and zero-pair flag alongside the quotient
  vpk_delay #(.W(2), .D(ALPHA_QW)) u_dly_aside (
    .clk   (clk),
    .en    (en),
    .d_in  ({fo.neg, fo.zero}),
    .d_out (a_side)
  );

  always_comb begin
    if (a_side[0]) begin
      alpha_nxt = '0;
    end else if (a_side[1]) begin
      alpha_nxt = a_ovf ? ALPHA_MIN : (ALPHA_W'(0) - ALPHA_W'(aq));
    end else begin
      alpha_nxt = a_ovf ? ALPHA_MAX : ALPHA_W'(aq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= alpha_nxt;
    end
  end

  vpk_delay #(.W(ALPHA_W), .D(LAT - ALPHA_DONE)) u_dly_alpha (
    .clk   (clk),
    .en    (en),
    .d_in  (alpha_r),
    .d_out (alpha_d)
  );

  // ---------------------------------------------------------------------
  // qt path: |pP x pN|^2 over |pP + pN|^2, overflow flagged, then square root
  // ---------------------------------------------------------------------
  logic [QT_QW-1:0] qq;
  logic             q_ovf;
  logic             q_ovf_d;
  logic [QT_K-1:0]  qt_root;
  logic             q_zero_d;
  logic [QT_W-1:0]  qt_r;
  logic             zero_q_r;

  vpk_div #(.NW(CN_W), .DW(DEN_W), .QW(QT_QW)) u_div_qt (
    .clk (clk),
    .en  (en),
    .num (fo.cn),
    .den (fo.den),
    .quo (qq),
    .ovf (q_ovf)
  );

  vpk_isqrt #(.RW(QT_QW)) u_sqrt_qt (
    .clk  (clk),
    .en   (en),
    .rad  (qq),
    .root (qt_root)
  );

  vpk_delay #(.W(1), .D(QT_K)) u_dly_qovf (
    .clk   (clk),
    .en    (en),
    .d_in  (q_ovf),
    .d_out (q_ovf_d)
  );

  vpk_delay #(.W(1), .D(QT_QW + QT_K)) u_dly_qzero (
    .clk   (clk),
    .en    (en),
    .d_in  (fo.zero),
    .d_out (q_zero_d)
  );

  // quotient at or above the cap gives a root beyond the field: clamp
  always_ff @(posedge clk) begin
    if (en) begin
      if (q_zero_d) begin
        qt_r <= '0;
      end else if (q_ovf_d) begin
        qt_r <= QT_MAX;
      end else begin
        qt_r <= QT_W'(qt_root);
      end
      zero_q_r <= q_zero_d;
    end
  end

  // ---------------------------------------------------------------------
  // output buffer
  // ---------------------------------------------------------------------
  assign res_last.inv_mass_sq = mass_d;
  assign res_last.ap_alpha    = alpha_d;
  assign res_last.ap_qt       = qt_r;
  assign res_last.zero_pair   = zero_q_r;

  assign push = en && vld_r[LAT-1];
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res_last;
    end
  end

  assign out_chan.valid       = cnt_r != 2'd0;
  assign out_chan.inv_mass_sq = buf_r[rd_ptr_r].inv_mass_sq;
  assign out_chan.ap_alpha    = buf_r[rd_ptr_r].ap_alpha;
  assign out_chan.ap_qt       = buf_r[rd_ptr_r].ap_qt;
  assign out_chan.zero_pair   = buf_r[rd_ptr_r].zero_pair;

endmodule

// ===== dv/tb_v0_pair_kinematics.sv =====
// tb_v0_pair_kinematics: self-checking testbench for the pair kinematics block
// needs vpk_pkg, vpk_in_if, vpk_out_if and the v0_pair_kinematics rtl
module tb_v0_pair_kinematics;
  import vpk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 750;
  localparam int STALL_LIM  = 2000;   // cycles without any request moving
  localparam int DRAIN_WAIT = 100;    // longer than the pipeline latency
  localparam int PAUSE_AT   = 300;    // random request before which the sender drains

  localparam mom_t MOM_MAX = 24'sh7FFFFF;
  localparam mom_t MOM_MIN = 24'sh800000;
  localparam mom_t UNIT    = 24'sh010000;   // 1.0 in q.16
  localparam msq_t MSQ_MAX = 24'hFFFFFF;

  typedef struct {
    vpk_item_t item;
    bit        known;   // expected result typed in below
    vpk_res_t  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vpk_in_if  in_chan ();
  vpk_out_if out_chan ();

  v0_pair_kinematics dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vpk_res_t  kin_expected_q[$];
  stim_row_t stim_table[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;         // no idling on either side while set

  // floor of the square root, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // mass squared and armenteros alpha and qt for one candidate
  function automatic vpk_res_t predict_kinematics(vpk_item_t it);
    logic signed [127:0] p[3], n[3], v[3], s[3], c[3];
    logic [127:0] sq_p, sq_n, sq_v, den, e, e2, d, num, q, cn;
    logic [63:0] qt;
    vpk_res_t res;
    p[0] = it.pos_px;  p[1] = it.pos_py;  p[2] = it.pos_pz;
    n[0] = it.neg_px;  n[1] = it.neg_py;  n[2] = it.neg_pz;
    v[0] = it.pair_px; v[1] = it.pair_py; v[2] = it.pair_pz;
    for (int i = 0; i < 3; i++) s[i] = p[i] + n[i];
    sq_p = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
    sq_n = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    sq_v = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    den  = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
    res = '0;

    // energies floored, mass difference floored to q.16
    e = floor_sqrt(64'((128'(it.pos_mass_sq) << FRAC_W) + sq_p))
      + floor_sqrt(64'((128'(it.neg_mass_sq) << FRAC_W) + sq_n));
    e2 = e * e;
    if (e2 >= sq_v) begin
      d = (e2 - sq_v) >> FRAC_W;
      if (d > (128'd1 << 39) - 1) d = (128'd1 << 39) - 1;
      res.inv_mass_sq = d[MASS_W-1:0];
    end else begin
      d = (sq_v - e2 + (128'd1 << FRAC_W) - 1) >> FRAC_W;
      if (d > (128'd1 << 39)) d = 128'd1 << 39;
      res.inv_mass_sq = -d[MASS_W-1:0];
    end

    res.zero_pair = (den == 0);
    if (den != 0) begin
      // alpha truncated toward zero, then saturated
      num = (sq_n > sq_p) ? sq_n - sq_p : sq_p - sq_n;
      q = (num << FRAC_W) / den;
      if (q > 128'h800000) q = 128'h800000;
      if (sq_n > sq_p) res.ap_alpha = -q[ALPHA_W-1:0];
      else res.ap_alpha = (q > 128'h7FFFFF) ? ALPHA_MAX : q[ALPHA_W-1:0];

      // qt from the cross product
      c[0] = p[1] * n[2] - p[2] * n[1];
      c[1] = p[2] * n[0] - p[0] * n[2];
      c[2] = p[0] * n[1] - p[1] * n[0];
      cn = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
      q = cn / den;
      if (q > (128'd1 << 48)) q = 128'd1 << 48;
      qt = floor_sqrt(q[63:0]);
      res.ap_qt = (qt > 64'hFFFFFF) ? QT_MAX : qt[QT_W-1:0];
    end
    return res;
  endfunction

  function automatic vpk_item_t make_item(mom_t ppx, mom_t ppy, mom_t ppz,
                                          mom_t npx, mom_t npy, mom_t npz,
                                          mom_t vx, mom_t vy, mom_t vz,
                                          msq_t mp, msq_t mn);
    vpk_item_t it;
    it.pos_px = ppx;  it.pos_py = ppy;  it.pos_pz = ppz;
    it.neg_px = npx;  it.neg_py = npy;  it.neg_pz = npz;
    it.pair_px = vx;  it.pair_py = vy;  it.pair_pz = vz;
    it.pos_mass_sq = mp;
    it.neg_mass_sq = mn;
    return it;
  endfunction

  function automatic void add_row(vpk_item_t it, bit known,
                                  logic signed [MASS_W-1:0] m, logic signed [ALPHA_W-1:0] a,
                                  logic [QT_W-1:0] qt, logic z);
    stim_row_t row;
    row.item = it;
    row.known = known;
    row.res.inv_mass_sq = m;
    row.res.ap_alpha = a;
    row.res.ap_qt = qt;
    row.res.zero_pair = z;
    stim_table.push_back(row);
  endfunction

  function automatic mom_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return MOM_MAX;
      1: return MOM_MIN;
      2: return 24'sd0;
      3: return 24'sd1;
      4: return -24'sd1;
      default: return mom_t'($urandom);
    endcase
  endfunction

  // signed momentum within about +-16 gev
  function automatic mom_t pick_physical();
    return mom_t'($signed($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic vpk_item_t random_item();
    vpk_item_t it;
    int kind;
    it = vpk_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom});
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // well-formed candidate: pair momentum mostly the prong sum, light masses
      it.pos_px = pick_physical(); it.pos_py = pick_physical(); it.pos_pz = pick_physical();
      it.neg_px = pick_physical(); it.neg_py = pick_physical(); it.neg_pz = pick_physical();
      it.pair_px = it.pos_px + it.neg_px;
      it.pair_py = it.pos_py + it.neg_py;
      it.pair_pz = it.pos_pz + it.neg_pz;
      if ($urandom_range(0, 4) == 0) it.pair_px = it.pair_px + mom_t'($urandom_range(0, 255));
      it.pos_mass_sq = msq_t'($urandom_range(0, 262144));
      it.neg_mass_sq = msq_t'($urandom_range(0, 262144));
    end else if (kind < 70) begin
      // back to back prongs, pair sum vanishes
      it.neg_px = -it.pos_px; it.neg_py = -it.pos_py; it.neg_pz = -it.pos_pz;
    end else if (kind < 85) begin
      it.pos_px = pick_extreme(); it.pos_py = pick_extreme(); it.pos_pz = pick_extreme();
      it.neg_px = pick_extreme(); it.neg_py = pick_extreme(); it.neg_pz = pick_extreme();
      it.pair_px = pick_extreme(); it.pair_py = pick_extreme(); it.pair_pz = pick_extreme();
      if ($urandom_range(0, 1) == 0) it.pos_mass_sq = MSQ_MAX;
    end else if (kind < 90) begin
      it.neg_px = '0; it.neg_py = '0; it.neg_pz = '0;
    end
    return it;
  endfunction

  task automatic drive_item(vpk_item_t it);
    in_chan.pos_px <= it.pos_px;
    in_chan.pos_py <= it.pos_py;
    in_chan.pos_pz <= it.pos_pz;
    in_chan.neg_px <= it.neg_px;
    in_chan.neg_py <= it.neg_py;
    in_chan.neg_pz <= it.neg_pz;
    in_chan.pair_px <= it.pair_px;
    in_chan.pair_py <= it.pair_py;
    in_chan.pair_pz <= it.pair_pz;
    in_chan.pos_mass_sq <= it.pos_mass_sq;
    in_chan.neg_mass_sq <= it.neg_mass_sq;
  endtask

  // one request: optional idle gap, then hold until accepted
  task automatic send_request(vpk_item_t it, vpk_res_t exp_res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drive_item(it);
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    kin_expected_q.push_back(exp_res);
    @(negedge clk);
  endtask

  // directed rows; typed results only where they follow by inspection
  initial begin
    // all zero: zero pair flag, everything else zero
    add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0, 0, 1'b1);
    // massless positive prong of 1.0 along x carries the whole pair
    add_row(make_item(UNIT, 0, 0, 0, 0, 0, UNIT, 0, 0, 0, 0), 1'b1, 0, 24'sh010000, 0, 1'b0);
    // same with only the negative prong: alpha is -1.0
    add_row(make_item(0, 0, 0, UNIT, 0, 0, UNIT, 0, 0, 0, 0), 1'b1, 0, -24'sh010000, 0, 1'b0);
    // back to back unit prongs: energy 2.0, mass squared 4.0, zero pair
    add_row(make_item(UNIT, 0, 0, -UNIT, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            40'sh0000040000, 0, 0, 1'b1);
    // extremes of every field, checked against the predictor
    add_row(make_item(MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX,
                      MOM_MAX, MOM_MAX, MOM_MAX, MSQ_MAX, MSQ_MAX), 1'b0, 0, 0, 0, 0);
    add_row(make_item(MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN,
                      MOM_MIN, MOM_MIN, MOM_MIN, 0, 0), 1'b0, 0, 0, 0, 0);
    add_row(make_item(MOM_MAX, MOM_MIN, MOM_MAX, MOM_MIN, MOM_MAX, MOM_MIN,
                      MOM_MIN, MOM_MAX, MOM_MIN, MSQ_MAX, 0), 1'b0, 0, 0, 0, 0);
    // heavy masses at rest
    add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, MSQ_MAX, MSQ_MAX), 1'b0, 0, 0, 0, 0);
    // huge pair momentum, tiny energies: negative mass squared
    add_row(make_item(1, 0, 0, 0, 0, 0, MOM_MIN, MOM_MIN, MOM_MIN, 0, 0), 1'b0, 0, 0, 0, 0);
    // near-cancelling prongs: alpha saturates high, then low
    add_row(make_item(MOM_MAX, 0, 0, mom_t'(MOM_MIN + 2), 0, 0, 1, 0, 0, 0, 0),
            1'b0, 0, 0, 0, 0);
    add_row(make_item(mom_t'(MOM_MIN + 2), 0, 0, MOM_MAX, 0, 0, 1, 0, 0, 0, 0),
            1'b0, 0, 0, 0, 0);
    // large transverse momentum, qt large but below its ceiling
    add_row(make_item(MOM_MAX, MOM_MAX, 0, mom_t'(MOM_MIN + 1), MOM_MAX, 0, 0, MOM_MAX, 0,
                      0, 0),
            1'b0, 0, 0, 0, 0);
    add_row(make_item(0, MOM_MAX, MOM_MIN, MOM_MIN, 0, MOM_MAX, 0, 0, 0, 1, 1),
            1'b0, 0, 0, 0, 0);
    // single lsb prongs
    add_row(make_item(1, 0, 0, 0, -1, 0, 1, -1, 0, 1, 1), 1'b0, 0, 0, 0, 0);
  end

  // sender: directed table, then random requests with one drain pause
  initial begin
    vpk_item_t it;
    in_chan.valid = 1'b0;
    drive_item('0);
    out_chan.ready = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[i])
      send_request(stim_table[i].item,
                   stim_table[i].known ? stim_table[i].res
                                       : predict_kinematics(stim_table[i].item));

    for (int k = 0; k < N_RANDOM; k++) begin
      calm = ((k / 64) % 4) == 3;
      if (k == PAUSE_AT) begin
        // hold off until every outstanding request has come back
        in_chan.valid <= 1'b0;
        while (kin_expected_q.size() != 0) @(negedge clk);
      end
      it = random_item();
      send_request(it, predict_kinematics(it));
    end
    in_chan.valid <= 1'b0;

    while (kin_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("v0_pair_kinematics: match");
    end else begin
      $display("v0_pair_kinematics: mismatch");
    end
    $finish;
  end

  // receiver back-pressure: random stall before each result
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      @(negedge clk);
    end
  end

  // result checker against the oldest outstanding expectation
  always @(posedge clk) begin
    vpk_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (kin_expected_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = kin_expected_q.pop_front();
        if (out_chan.inv_mass_sq !== want.inv_mass_sq) begin
          $error("inv_mass_sq expected %0d actual %0d", want.inv_mass_sq,
                 out_chan.inv_mass_sq);
          fail_count++;
        end
        if (out_chan.ap_alpha !== want.ap_alpha) begin
          $error("ap_alpha expected %0d actual %0d", want.ap_alpha, out_chan.ap_alpha);
          fail_count++;
        end
        if (out_chan.ap_qt !== want.ap_qt) begin
          $error("ap_qt expected %0d actual %0d", want.ap_qt, out_chan.ap_qt);
          fail_count++;
        end
        if (out_chan.zero_pair !== want.zero_pair) begin
          $error("zero_pair expected %0b actual %0b", want.zero_pair, out_chan.zero_pair);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long with no request moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIM) begin
        $display("v0_pair_kinematics: mismatch");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/vpk_pkg.sv
rtl/vpk_if.sv
rtl/vpk_delay.sv
rtl/vpk_div.sv
rtl/vpk_isqrt.sv
rtl/vpk_front.sv
rtl/v0_pair_kinematics.sv
dv/tb_v0_pair_kinematics.sv
